/* rtl/mbpm_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the power meter
// reply decoder. No dependencies.
package mbpm_pkg;

  localparam int unsigned PosWidth = 5;
  localparam int unsigned PayloadBytes = 14;

  localparam logic [7:0] FUNC_READ = 8'h03;
  localparam logic [7:0] BYTE_COUNT = 8'd14;
  localparam logic [PosWidth-1:0] POS_HUNT = 5'd0;
  localparam logic [PosWidth-1:0] POS_FUNC = 5'd1;
  localparam logic [PosWidth-1:0] POS_COUNT = 5'd2;
  localparam logic [PosWidth-1:0] POS_PAYLOAD = 5'd3;
  localparam logic [PosWidth-1:0] POS_CRC_LOW = 5'd17;
  localparam logic [PosWidth-1:0] POS_CRC_HIGH = 5'd18;

  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [3:0] FAIL_MAX = 4'd15;

  localparam logic CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic CFG_FAILURE_LIMIT = 1'b1;

  localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'd1;
  localparam logic [3:0] FAILURE_LIMIT_RESET = 4'd10;

  // mag / 10 = ((mag >> 1) * VOLT_RECIP) >> VOLT_SHIFT for 15-bit magnitudes
  localparam logic [14:0] VOLT_RECIP = 15'd26215;
  localparam int unsigned VOLT_SHIFT = 17;
  localparam logic [23:0] POWER_MULT = 24'd500;
  // 25 * 65536 = 18 * 91000 + 400
  localparam logic [31:0] ENERGY_HI_MULT = 32'd91000;
  localparam logic [23:0] ENERGY_HI_REM = 24'd400;
  localparam logic [23:0] ENERGY_LO_MULT = 24'd25;
  // n / 9 = (n * RECIP9) >> 27 for n below 2^23
  localparam logic [46:0] RECIP9 = 47'd14913081;
  localparam int unsigned RECIP9_SHIFT = 27;

  typedef struct packed {
    logic        v_neg;
    logic [14:0] v_mag;
    logic        c_neg;
    logic [14:0] c_mag;
    logic        p_neg;
    logic [14:0] p_mag;
    logic        f_neg;
    logic [30:0] f_mag;
    logic        r_neg;
    logic [30:0] r_mag;
  } held_t;

  typedef struct packed {
    logic       status;
    logic [3:0] failures;
    held_t      held;
  } frame_result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/mbpm_frame_rx.sv */
// Frame hunting, CRC check, payload capture and held values for the decoder.
// Depends on mbpm_pkg.
module mbpm_frame_rx (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             rx_byte,
  input  logic                   buffer_end,
  output logic                   res_valid,
  input  logic                   res_advance,
  output mbpm_pkg::frame_result_t res
);

  logic [7:0]                     slave_address;
  logic [3:0]                     failure_limit;
  logic [mbpm_pkg::PosWidth-1:0]  pos;
  logic [mbpm_pkg::PosWidth-1:0]  pos_next;
  logic [15:0]                    crc;
  logic [15:0]                    crc_next;
  logic [7:0]                     crc_low;
  logic [7:0]                     crc_low_next;
  logic [3:0]                     fail_count;
  logic [3:0]                     fail_count_next;
  logic [3:0]                     fail_inc;
  mbpm_pkg::held_t                held;
  mbpm_pkg::held_t                held_next;
  mbpm_pkg::held_t                decoded;
  logic                           status;
  logic                           status_next;
  logic [7:0]                     store [mbpm_pkg::PayloadBytes];
  logic [3:0]                     store_idx;
  logic                           store_we;
  logic                           accept;
  logic                           complete;
  logic                           good;
  logic                           hit;
  logic [mbpm_pkg::PosWidth-1:0]  restart_pos;
  logic [15:0]                    restart_crc;
  logic [15:0]                    crc_step;

  assign in_stall = res_valid && !res_advance;
  assign accept = in_valid && !in_stall;

  assign hit = rx_byte == slave_address;
  assign restart_pos = hit ? mbpm_pkg::POS_FUNC : mbpm_pkg::POS_HUNT;
  assign restart_crc = hit ? mbpm_pkg::crc16_byte(mbpm_pkg::CRC_START, rx_byte)
                           : mbpm_pkg::CRC_START;
  assign crc_step = mbpm_pkg::crc16_byte(crc, rx_byte);
  assign good = crc == {rx_byte, crc_low};
  assign fail_inc = (fail_count == mbpm_pkg::FAIL_MAX) ? fail_count : fail_count + 4'd1;
  assign store_idx = 4'(pos - mbpm_pkg::POS_PAYLOAD);

  assign decoded.v_neg = store[0][7];
  assign decoded.v_mag = {store[0][6:0], store[1]};
  assign decoded.c_neg = store[2][7];
  assign decoded.c_mag = {store[2][6:0], store[3]};
  assign decoded.p_neg = store[4][7];
  assign decoded.p_mag = {store[4][6:0], store[5]};
  assign decoded.f_neg = store[6][7];
  assign decoded.f_mag = {store[6][6:0], store[7], store[8], store[9]};
  assign decoded.r_neg = store[10][7];
  assign decoded.r_mag = {store[10][6:0], store[11], store[12], store[13]};

  always_comb begin
    pos_next = pos;
    crc_next = crc;
    crc_low_next = crc_low;
    fail_count_next = fail_count;
    held_next = held;
    status_next = status;
    complete = 1'b0;
    store_we = 1'b0;
    if (accept) begin
      priority if (pos == mbpm_pkg::POS_HUNT) begin
        pos_next = restart_pos;
        crc_next = restart_crc;
      end else if (pos == mbpm_pkg::POS_FUNC) begin
        if (rx_byte == mbpm_pkg::FUNC_READ) begin
          pos_next = mbpm_pkg::POS_COUNT;
          crc_next = crc_step;
        end else begin
          pos_next = restart_pos;
          crc_next = restart_crc;
        end
      end else if (pos == mbpm_pkg::POS_COUNT) begin
        if (rx_byte == mbpm_pkg::BYTE_COUNT) begin
          pos_next = mbpm_pkg::POS_PAYLOAD;
          crc_next = crc_step;
        end else begin
          pos_next = restart_pos;
          crc_next = restart_crc;
        end
      end else if (pos < mbpm_pkg::POS_CRC_LOW) begin
        store_we = 1'b1;
        crc_next = crc_step;
        pos_next = pos + 5'd1;
      end else if (pos == mbpm_pkg::POS_CRC_LOW) begin
        crc_low_next = rx_byte;
        pos_next = mbpm_pkg::POS_CRC_HIGH;
      end else if (pos == mbpm_pkg::POS_CRC_HIGH) begin
        complete = 1'b1;
        status_next = !good;
        if (good) begin
          held_next = decoded;
          fail_count_next = 4'd0;
        end else begin
          fail_count_next = fail_inc;
          if (fail_inc > failure_limit) begin
            held_next = '0;
          end
        end
        pos_next = mbpm_pkg::POS_HUNT;
        crc_next = mbpm_pkg::CRC_START;
      end else begin
        pos_next = mbpm_pkg::POS_HUNT;
        crc_next = mbpm_pkg::CRC_START;
      end
      if (buffer_end && !complete) begin
        pos_next = mbpm_pkg::POS_HUNT;
        crc_next = mbpm_pkg::CRC_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= mbpm_pkg::SLAVE_ADDRESS_RESET;
      failure_limit <= mbpm_pkg::FAILURE_LIMIT_RESET;
      pos <= mbpm_pkg::POS_HUNT;
      crc <= mbpm_pkg::CRC_START;
      crc_low <= 8'd0;
      fail_count <= 4'd0;
      held <= '0;
      status <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          mbpm_pkg::CFG_SLAVE_ADDRESS: slave_address <= cfg_data;
          mbpm_pkg::CFG_FAILURE_LIMIT: failure_limit <= cfg_data[3:0];
          default: ;
        endcase
      end
      pos <= pos_next;
      crc <= crc_next;
      crc_low <= crc_low_next;
      fail_count <= fail_count_next;
      held <= held_next;
      status <= status_next;
      res_valid <= (res_valid && !res_advance) || complete;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[store_idx] <= rx_byte;
    end
  end

  assign res.status = status;
  assign res.failures = fail_count;
  assign res.held = held;

endmodule

/* rtl/modbus_power_meter_frame_decoder.sv */
// Top level of the power meter reply decoder: frame receiver plus scaling pipeline.
// Depends on mbpm_pkg and mbpm_frame_rx.
//
// One received byte is taken in every clock cycle unless the input is stalled.
// The byte that completes a frame (the CRC high byte) loads the receiver's
// result register, and its result item then passes through a three-stage
// scaling pipeline (the s2, s3 and output registers): a constant multiply
// stage, a reciprocal multiply stage for the energy divide by 18, and a final
// add and sign stage. Every other byte yields no item. Input is stalled only
// when a finished frame sits in the result register while every stage ahead
// of it is full and the output is stalled; since frames are at least 19 bytes
// apart, a waiting output item does not hold up the bytes of the next frame.
module modbus_power_meter_frame_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               buffer_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               frame_status,
  output logic signed [12:0] voltage_scaled,
  output logic signed [14:0] current_scaled,
  output logic signed [24:0] power_scaled,
  output logic signed [32:0] forward_energy_scaled,
  output logic signed [32:0] reverse_energy_scaled,
  output logic signed [31:0] forward_energy_raw,
  output logic signed [31:0] reverse_energy_raw,
  output logic [3:0]         failures_seen
);

  mbpm_pkg::frame_result_t res;
  logic                    res_valid;
  logic                    adv2;
  logic                    adv3;
  logic                    adv4;

  logic                    s2_valid;
  logic                    s2_status;
  logic [3:0]              s2_failures;
  logic                    s2_v_neg;
  logic [11:0]             s2_v_q;
  logic                    s2_c_neg;
  logic [13:0]             s2_c_q;
  logic                    s2_p_neg;
  logic [23:0]             s2_p_m;
  logic                    s2_f_neg;
  logic [30:0]             s2_f_mag;
  logic [31:0]             s2_f_q1;
  logic [23:0]             s2_f_t;
  logic                    s2_r_neg;
  logic [30:0]             s2_r_mag;
  logic [31:0]             s2_r_q1;
  logic [23:0]             s2_r_t;
  logic [28:0]             v_prod;

  logic                    s3_valid;
  logic                    s3_status;
  logic [3:0]              s3_failures;
  logic                    s3_v_neg;
  logic [11:0]             s3_v_q;
  logic                    s3_c_neg;
  logic [13:0]             s3_c_q;
  logic                    s3_p_neg;
  logic [23:0]             s3_p_m;
  logic                    s3_f_neg;
  logic [30:0]             s3_f_mag;
  logic [31:0]             s3_f_q1;
  logic [19:0]             s3_f_d;
  logic                    s3_r_neg;
  logic [30:0]             s3_r_mag;
  logic [31:0]             s3_r_q1;
  logic [19:0]             s3_r_d;
  logic [46:0]             f_prod;
  logic [46:0]             r_prod;
  logic [32:0]             f_sum;
  logic [32:0]             r_sum;

  mbpm_frame_rx u_rx (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .buffer_end (buffer_end),
    .res_valid  (res_valid),
    .res_advance(adv2),
    .res        (res)
  );

  assign adv4 = !out_valid || !out_stall;
  assign adv3 = !s3_valid || adv4;
  assign adv2 = !s2_valid || adv3;

  assign v_prod = 29'(res.held.v_mag[14:1]) * 29'(mbpm_pkg::VOLT_RECIP);
  assign f_prod = 47'(s2_f_t[23:1]) * mbpm_pkg::RECIP9;
  assign r_prod = 47'(s2_r_t[23:1]) * mbpm_pkg::RECIP9;
  assign f_sum = {1'b0, s3_f_q1 + 32'(s3_f_d)};
  assign r_sum = {1'b0, s3_r_q1 + 32'(s3_r_d)};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv2) begin
        s2_valid <= res_valid;
      end
      if (adv3) begin
        s3_valid <= s2_valid;
      end
      if (adv4) begin
        out_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_status <= res.status;
      s2_failures <= res.failures;
      s2_v_neg <= res.held.v_neg;
      s2_v_q <= v_prod[mbpm_pkg::VOLT_SHIFT+11:mbpm_pkg::VOLT_SHIFT];
      s2_c_neg <= res.held.c_neg;
      s2_c_q <= res.held.c_mag[14:1];
      s2_p_neg <= res.held.p_neg;
      s2_p_m <= 24'(res.held.p_mag) * mbpm_pkg::POWER_MULT;
      s2_f_neg <= res.held.f_neg;
      s2_f_mag <= res.held.f_mag;
      s2_f_q1 <= 32'(res.held.f_mag[30:16]) * mbpm_pkg::ENERGY_HI_MULT;
      s2_f_t <= 24'(res.held.f_mag[30:16]) * mbpm_pkg::ENERGY_HI_REM
              + 24'(res.held.f_mag[15:0]) * mbpm_pkg::ENERGY_LO_MULT;
      s2_r_neg <= res.held.r_neg;
      s2_r_mag <= res.held.r_mag;
      s2_r_q1 <= 32'(res.held.r_mag[30:16]) * mbpm_pkg::ENERGY_HI_MULT;
      s2_r_t <= 24'(res.held.r_mag[30:16]) * mbpm_pkg::ENERGY_HI_REM
              + 24'(res.held.r_mag[15:0]) * mbpm_pkg::ENERGY_LO_MULT;
    end
    if (adv3) begin
      s3_status <= s2_status;
      s3_failures <= s2_failures;
      s3_v_neg <= s2_v_neg;
      s3_v_q <= s2_v_q;
      s3_c_neg <= s2_c_neg;
      s3_c_q <= s2_c_q;
      s3_p_neg <= s2_p_neg;
      s3_p_m <= s2_p_m;
      s3_f_neg <= s2_f_neg;
      s3_f_mag <= s2_f_mag;
      s3_f_q1 <= s2_f_q1;
      s3_f_d <= f_prod[mbpm_pkg::RECIP9_SHIFT+19:mbpm_pkg::RECIP9_SHIFT];
      s3_r_neg <= s2_r_neg;
      s3_r_mag <= s2_r_mag;
      s3_r_q1 <= s2_r_q1;
      s3_r_d <= r_prod[mbpm_pkg::RECIP9_SHIFT+19:mbpm_pkg::RECIP9_SHIFT];
    end
    if (adv4) begin
      frame_status <= s3_status;
      failures_seen <= s3_failures;
      voltage_scaled <= s3_v_neg ? -$signed({1'b0, s3_v_q}) : $signed({1'b0, s3_v_q});
      current_scaled <= s3_c_neg ? -$signed({1'b0, s3_c_q}) : $signed({1'b0, s3_c_q});
      power_scaled <= s3_p_neg ? -$signed({1'b0, s3_p_m}) : $signed({1'b0, s3_p_m});
      forward_energy_scaled <= s3_f_neg ? -$signed(f_sum) : $signed(f_sum);
      reverse_energy_scaled <= s3_r_neg ? -$signed(r_sum) : $signed(r_sum);
      forward_energy_raw <= s3_f_neg ? -$signed({1'b0, s3_f_mag}) : $signed({1'b0, s3_f_mag});
      reverse_energy_raw <= s3_r_neg ? -$signed({1'b0, s3_r_mag}) : $signed({1'b0, s3_r_mag});
    end
  end

endmodule
